[hw/rtl/bbl_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bbl_pkg
// Types and constants shared by the 3x3 box blur stream block.
// ----------------------------------------------------------------------------
package bbl_pkg;

	localparam int CFG_DATA_W = 13;
	localparam int CFG_IDX_W  = 2;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

	localparam int FW_REG_W = 11;
	localparam int FH_REG_W = 13;

	localparam int CMD_PIXEL = 0;
	localparam int CMD_DRAIN = 1;

	// Channel 2 is red, 1 is green, 0 is blue.
	typedef logic [2:0][7:0] rgb_t;

	typedef struct packed {
		logic       cmd;
		logic [7:0] red_in;
		logic [7:0] green_in;
		logic [7:0] blue_in;
	} bbl_in_t;

	typedef struct packed {
		logic [7:0] red_out;
		logic [7:0] green_out;
		logic [7:0] blue_out;
		logic       frame_end;
	} bbl_out_t;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_READ = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_DONE = 4'b1000
	} bbl_state_t;

endpackage
`default_nettype wire

[hw/rtl/bbl_stream_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bbl_stream_if
// Valid/ready channel carrying one payload of type T per transaction.
// ----------------------------------------------------------------------------
interface bbl_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[hw/rtl/box_blur_3x3_rgb_stream.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// box_blur_3x3_rgb_stream
// 3x3 box blur over an RGB raster stream, with a ring of recent pixels in RAM.
// ----------------------------------------------------------------------------
// Pixels enter in raster order and each result is the rounded mean of the
// in-frame 3x3 neighbors, emitted frame_width+1 transactions behind the input;
// drain transactions (cmd = 1) flush the tail of a finished frame. The ring of
// 2*MAX_WIDTH+4 pixels lives in one single-port-write RAM with a registered
// read. A transaction that causes no result is only accepted in ST_IDLE; one
// that releases a result passes through the accepting cycle, nine RAM reads,
// a radix-2 divider shared by the three channels (the registered read of the
// last window pixel is folded in at its first step), and the load of the
// output register. A stalled output holds the block in ST_DONE. A write to
// the width or height register restarts the stream.
module box_blur_3x3_rgb_stream
	import bbl_pkg::*;
#(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 4096
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	bbl_stream_if.sink                 pix_in,
	bbl_stream_if.source               pix_out
);

	localparam int RING = 2 * MAX_WIDTH + 4;
	localparam int AW   = $clog2(RING);
	localparam int WW   = $clog2(MAX_WIDTH + 1);
	localparam int HW   = $clog2(MAX_HEIGHT + 1);
	localparam int CW   = $clog2(MAX_WIDTH);
	localparam int RW   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int PW   = $clog2(MAX_WIDTH + 3);

	bbl_state_t state_q;

	logic [WW-1:0] w_q;
	logic [HW-1:0] h_q;
	logic [CW-1:0] in_col_q, out_col_q, ctr_col_q;
	logic [RW-1:0] in_row_q, out_row_q, ctr_row_q;
	logic [PW-1:0] pend_q;
	logic [AW-1:0] wr_q, addr_q;
	logic [1:0]    dr_q, dc_q;
	logic          fend_q;

	rgb_t          ring_mem [RING];
	rgb_t          rdata_s1;
	logic          rvld_s1, mask_s1;

	logic [11:0]   acc_q [3];
	logic [3:0]    cnt_q;
	logic [12:0]   rem_q [3];
	logic [7:0]    quo_q [3];
	logic [4:0]    dvs_q;
	logic [2:0]    bit_q;

	bbl_out_t      out_q;
	logic          out_vld_q;

	// ------------------------------------------------------------------
	// Input decode
	// ------------------------------------------------------------------
	logic          acc_in, is_pix, emit, col_wrap, row_wrap;
	logic [PW-1:0] pend_new, pn;
	logic [AW-1:0] wr_new, wp, a0;
	logic [31:0]   span;
	rgb_t          px_in;

	assign pix_in.ready = (state_q == ST_IDLE);
	assign acc_in       = pix_in.valid && pix_in.ready;
	assign is_pix       = (pix_in.data.cmd == 1'(CMD_PIXEL));
	assign px_in        = {pix_in.data.red_in, pix_in.data.green_in, pix_in.data.blue_in};

	always_comb begin
		col_wrap = (WW'(in_col_q) + WW'(1)) == w_q;
		row_wrap = (HW'(in_row_q) + HW'(1)) == h_q;
		pend_new = pend_q + PW'(1);
		wr_new   = (32'(wr_q) == RING - 1) ? '0 : wr_q + AW'(1);
		if (is_pix) begin
			emit = 32'(pend_new) > 32'(w_q) + 32'd1;
		end else begin
			// Results beyond the pixels of the current frame belong to a complete one.
			emit = ((in_row_q == '0) && (32'(pend_q) > 32'(in_col_q)))
				|| ((in_row_q == RW'(1)) && (32'(pend_q) > 32'(w_q) + 32'(in_col_q)));
		end
		wp   = is_pix ? wr_new : wr_q;
		pn   = is_pix ? pend_new : pend_q;
		span = 32'(pn) + 32'(w_q) + 32'd1;
		if (32'(wp) >= span) begin
			a0 = AW'(32'(wp) - span);
		end else begin
			a0 = AW'(32'(wp) + RING - span);
		end
	end

	// ------------------------------------------------------------------
	// Window walk
	// ------------------------------------------------------------------
	logic [AW-1:0] step_w;
	logic [AW:0]   addr_sum;
	logic [AW-1:0] addr_nxt;
	logic          row_ok, col_ok;

	always_comb begin
		if (w_q >= WW'(2)) begin
			step_w = AW'(32'(w_q) - 32'd2);
		end else begin
			step_w = AW'(32'(w_q) + RING - 32'd2);
		end
		addr_sum = (AW+1)'(addr_q) + ((dc_q == 2'd2) ? (AW+1)'(step_w) : (AW+1)'(1));
		if (32'(addr_sum) >= RING) begin
			addr_nxt = AW'(32'(addr_sum) - RING);
		end else begin
			addr_nxt = addr_sum[AW-1:0];
		end
		case (dr_q)
			2'd0:    row_ok = (ctr_row_q != '0);
			2'd2:    row_ok = (32'(ctr_row_q) + 32'd1) < 32'(h_q);
			default: row_ok = 1'b1;
		endcase
		case (dc_q)
			2'd0:    col_ok = (ctr_col_q != '0);
			2'd2:    col_ok = (32'(ctr_col_q) + 32'd1) < 32'(w_q);
			default: col_ok = 1'b1;
		endcase
	end

	always_ff @(posedge clk) begin
		if (acc_in && is_pix) begin
			ring_mem[wr_q] <= px_in;
		end
		rdata_s1 <= ring_mem[addr_q];
	end

	logic [11:0] acc_nxt [3];
	logic [3:0]  cnt_nxt;
	logic        take;

	always_comb begin
		take    = rvld_s1 && mask_s1;
		cnt_nxt = cnt_q + (take ? 4'd1 : 4'd0);
		for (int ch = 0; ch < 3; ch++) begin
			acc_nxt[ch] = acc_q[ch] + (take ? 12'(rdata_s1[ch]) : 12'd0);
		end
	end

	// ------------------------------------------------------------------
	// Divider: one quotient bit per cycle for all three channels.
	// ------------------------------------------------------------------
	logic [12:0] dshift;
	assign dshift = 13'(dvs_q) << bit_q;

	// ------------------------------------------------------------------
	// Control and state
	// ------------------------------------------------------------------
	logic [31:0] wclamp, hclamp;
	always_comb begin
		wclamp = 32'(cfg_wdata[FW_REG_W-1:0]);
		if (wclamp == 32'd0) wclamp = 32'd1;
		else if (wclamp > MAX_WIDTH) wclamp = MAX_WIDTH;
		hclamp = 32'(cfg_wdata[FH_REG_W-1:0]);
		if (hclamp == 32'd0) hclamp = 32'd1;
		else if (hclamp > MAX_HEIGHT) hclamp = MAX_HEIGHT;
	end

	logic fin_read, out_free;
	assign fin_read = (dr_q == 2'd2) && (dc_q == 2'd2);
	assign out_free = !out_vld_q || pix_out.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			w_q       <= WW'(MAX_WIDTH < 1024 ? MAX_WIDTH : 1024);
			h_q       <= HW'(MAX_HEIGHT < 1024 ? MAX_HEIGHT : 1024);
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			pend_q    <= '0;
			wr_q      <= '0;
			addr_q    <= '0;
			dr_q      <= '0;
			dc_q      <= '0;
			rvld_s1   <= 1'b0;
			out_vld_q <= 1'b0;
			bit_q     <= '0;
		end else begin
			rvld_s1 <= (state_q == ST_READ);
			if (out_vld_q && pix_out.ready) begin
				out_vld_q <= 1'b0;
			end
			if (cfg_we && (cfg_idx == REG_FRAME_WIDTH || cfg_idx == REG_FRAME_HEIGHT)) begin
				if (cfg_idx == REG_FRAME_WIDTH) w_q <= WW'(wclamp);
				else h_q <= HW'(hclamp);
				in_col_q  <= '0;
				in_row_q  <= '0;
				out_col_q <= '0;
				out_row_q <= '0;
				pend_q    <= '0;
				wr_q      <= '0;
			end else begin
				case (state_q)
					ST_IDLE: begin
						if (acc_in) begin
							if (is_pix) begin
								wr_q <= wr_new;
								if (col_wrap) begin
									in_col_q <= '0;
									in_row_q <= row_wrap ? '0 : in_row_q + RW'(1);
								end else begin
									in_col_q <= in_col_q + CW'(1);
								end
							end
							if (emit) begin
								pend_q    <= pn - PW'(1);
								addr_q    <= a0;
								dr_q      <= '0;
								dc_q      <= '0;
								state_q   <= ST_READ;
								if ((WW'(out_col_q) + WW'(1)) == w_q) begin
									out_col_q <= '0;
									out_row_q <= ((HW'(out_row_q) + HW'(1)) == h_q)
										? '0 : out_row_q + RW'(1);
								end else begin
									out_col_q <= out_col_q + CW'(1);
								end
							end else begin
								pend_q <= pn;
							end
						end
					end
					ST_READ: begin
						addr_q <= addr_nxt;
						if (dc_q == 2'd2) begin
							dc_q <= '0;
							dr_q <= dr_q + 2'd1;
						end else begin
							dc_q <= dc_q + 2'd1;
						end
						if (fin_read) begin
							state_q <= ST_DIV;
							bit_q   <= 3'd7;
						end
					end
					ST_DIV: begin
						bit_q <= bit_q - 3'd1;
						if (bit_q == 3'd0) state_q <= ST_DONE;
					end
					ST_DONE: begin
						if (out_free) begin
							out_vld_q <= 1'b1;
							state_q   <= ST_IDLE;
						end
					end
					default: state_q <= ST_IDLE;
				endcase
			end
		end
	end

	// Payload registers: window center, sums, divider, result.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && acc_in && emit) begin
			ctr_col_q <= out_col_q;
			ctr_row_q <= out_row_q;
			fend_q    <= ((32'(out_row_q) + 32'd1) == 32'(h_q))
				&& ((32'(out_col_q) + 32'd1) == 32'(w_q));
			cnt_q     <= '0;
			for (int ch = 0; ch < 3; ch++) acc_q[ch] <= '0;
		end else begin
			cnt_q <= cnt_nxt;
			for (int ch = 0; ch < 3; ch++) acc_q[ch] <= acc_nxt[ch];
		end
		if (state_q == ST_READ) begin
			mask_s1 <= row_ok && col_ok;
		end
		if (state_q == ST_READ && fin_read) begin
			// The last window read is issued here and its data lands in the next cycle;
			// it is folded in at the first divider step instead, so the divisor is loaded later.
			dvs_q <= '0;
		end
		if (state_q == ST_DIV) begin
			dvs_q <= (bit_q == 3'd7) ? {cnt_nxt, 1'b0} : dvs_q;
			for (int ch = 0; ch < 3; ch++) begin
				logic [12:0] r;
				logic [4:0]  d;
				r = rem_q[ch];
				d = dvs_q;
				if (bit_q == 3'd7) begin
					r = 13'({acc_nxt[ch], 1'b0}) + 13'(cnt_nxt);
					d = {cnt_nxt, 1'b0};
				end
				if (r >= (13'(d) << bit_q)) begin
					rem_q[ch]        <= r - (13'(d) << bit_q);
					quo_q[ch][bit_q] <= 1'b1;
				end else begin
					rem_q[ch]        <= r;
					quo_q[ch][bit_q] <= 1'b0;
				end
			end
		end
		if (state_q == ST_DONE && out_free) begin
			out_q.red_out   <= quo_q[2];
			out_q.green_out <= quo_q[1];
			out_q.blue_out  <= quo_q[0];
			out_q.frame_end <= fend_q;
		end
	end

	assign pix_out.valid = out_vld_q;
	assign pix_out.data  = out_q;

	// Shifted divisor, used only by an assertion, kept for visibility of the current trial value.
	logic dshift_nz;
	assign dshift_nz = |dshift;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> 32'(pend_q) <= 32'(w_q) + 32'd1)
		else $error("pending results exceed frame_width+1");

	a_done_loads: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE && out_free && !cfg_we |=> out_vld_q)
		else $error("finished result not loaded into output register");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV && bit_q != 3'd7 |-> dvs_q != 5'd0 && dshift_nz)
		else $error("divider running with zero divisor");

endmodule
`default_nettype wire

[sim/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the 3x3 box blur over an RGB pixel stream.
// ----------------------------------------------------------------------------
// A short table of directed transactions runs first, then frames of random
// pixels under a series of frame sizes. Every accepted input goes through a
// cycle-free model of the blur, and each output transaction is compared with
// the oldest expected pixel. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
	import bbl_pkg::*;

	localparam int MAXW = 1024;
	localparam int MAXH = 4096;
	localparam int RING = 2 * MAXW + 4;
	localparam int IDLE_WAIT = 25;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int BROKEN_MAX = 120;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

	typedef enum logic [1:0] {ROW_PIX, ROW_DRN, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t             kind;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] val;
		logic [23:0]           rgb;
		bit                    typed;
		bbl_out_t              want;
	} stim_row_t;

	localparam int DIR_N = 24;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	bbl_stream_if #(.T(bbl_in_t))  pix_in_if ();
	bbl_stream_if #(.T(bbl_out_t)) pix_out_if ();

	box_blur_3x3_rgb_stream i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_wdata(cfg_wdata),
		.pix_in   (pix_in_if.sink),
		.pix_out  (pix_out_if.source)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Blur model state: the ring of recent pixels and the frame positions.
	logic [23:0] pix_ring [RING];
	int unsigned fr_w, fr_h, in_row, in_col, out_row, out_col, backlog, ring_wp;

	bbl_out_t blurred_q [$];
	int       mismatch_count = 0;
	int       idle_cycles = 0;
	bit       quiet = 1'b0;

	function automatic int unsigned clamp_reg(int unsigned v, int unsigned hi);
		if (v < 1) return 1;
		if (v > hi) return hi;
		return v;
	endfunction

	function automatic void blur_reset();
		foreach (pix_ring[i]) pix_ring[i] = '0;
		fr_w = 1024;
		fr_h = 1024;
		in_row = 0; in_col = 0; out_row = 0; out_col = 0; backlog = 0; ring_wp = 0;
	endfunction

	function automatic void blur_reg_write(logic [CFG_IDX_W-1:0] idx,
			logic [CFG_DATA_W-1:0] val);
		if (idx == REG_FRAME_WIDTH)
			fr_w = clamp_reg(val[FW_REG_W-1:0], MAXW);
		else if (idx == REG_FRAME_HEIGHT)
			fr_h = clamp_reg(val[FH_REG_W-1:0], MAXH);
		else
			return;
		in_row = 0; in_col = 0; out_row = 0; out_col = 0; backlog = 0; ring_wp = 0;
	endfunction

	function automatic bbl_out_t blur_release();
		bbl_out_t    res;
		int unsigned base, off, s_r, s_g, s_b, cnt;
		int          nr, nc;
		logic [23:0] px;
		base = (ring_wp + RING - backlog) % RING;
		s_r = 0; s_g = 0; s_b = 0; cnt = 0;
		for (int dr = -1; dr <= 1; dr++) begin
			for (int dc = -1; dc <= 1; dc++) begin
				nr = int'(out_row) + dr;
				nc = int'(out_col) + dc;
				if (nr >= 0 && nr < int'(fr_h) && nc >= 0 && nc < int'(fr_w)) begin
					off = (dr + 1) * fr_w + (dc + 1);
					px = pix_ring[(base + RING - fr_w - 1 + off) % RING];
					s_r += px[23:16];
					s_g += px[15:8];
					s_b += px[7:0];
					cnt++;
				end
			end
		end
		res.red_out   = 8'((2 * s_r + cnt) / (2 * cnt));
		res.green_out = 8'((2 * s_g + cnt) / (2 * cnt));
		res.blue_out  = 8'((2 * s_b + cnt) / (2 * cnt));
		res.frame_end = (out_row == fr_h - 1 && out_col == fr_w - 1);
		out_col++;
		if (out_col >= fr_w) begin
			out_col = 0;
			out_row++;
			if (out_row >= fr_h) out_row = 0;
		end
		backlog--;
		return res;
	endfunction

	function automatic bit drain_would_release();
		return backlog > in_row * fr_w + in_col;
	endfunction

	// Returns 1 and the blurred pixel when the transaction releases one.
	function automatic bit blur_step(bbl_in_t d, output bbl_out_t res);
		if (d.cmd == 1'(CMD_PIXEL)) begin
			pix_ring[ring_wp] = {d.red_in, d.green_in, d.blue_in};
			ring_wp = (ring_wp + 1) % RING;
			backlog++;
			in_col++;
			if (in_col >= fr_w) begin
				in_col = 0;
				in_row++;
				if (in_row >= fr_h) in_row = 0;
			end
			if (backlog > fr_w + 1) begin
				res = blur_release();
				return 1'b1;
			end
			return 1'b0;
		end
		if (drain_would_release()) begin
			res = blur_release();
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 55) return 0;
		if (r < 94) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Sends one transaction; the expectation is typed in or comes from the model.
	task automatic send(bbl_in_t d, bit typed = 1'b0, bbl_out_t want = '0);
		int       n;
		bit       got;
		bbl_out_t res;
		n = gap_len();
		if (n > 0) begin
			@(negedge clk);
			pix_in_if.valid <= 1'b0;
			repeat (n - 1) @(negedge clk);
		end
		@(negedge clk);
		pix_in_if.valid <= 1'b1;
		pix_in_if.data  <= d;
		@(posedge clk);
		while (!pix_in_if.ready) @(posedge clk);
		got = blur_step(d, res);
		if (typed) blurred_q.push_back(want);
		else if (got) blurred_q.push_back(res);
	endtask

	task automatic send_pixel();
		bbl_in_t d;
		d = $bits(bbl_in_t)'($urandom);
		d.cmd = 1'(CMD_PIXEL);
		send(d);
	endtask

	task automatic send_drain();
		bbl_in_t d;
		d = $bits(bbl_in_t)'($urandom);
		d.cmd = 1'(CMD_DRAIN);
		send(d);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		pix_in_if.valid <= 1'b0;
		while (blurred_q.size() != 0) @(posedge clk);
		// A dropped drain may still be in flight after the last result.
		repeat (IDLE_WAIT) @(negedge clk);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		blur_reg_write(idx, val);
	endtask

	// Whole frames of random pixels with stray drains; a broken run stops short.
	task automatic run_frames(int frames, bit broken);
		int total;
		total = frames * fr_w * fr_h;
		if (broken) total = $urandom_range(1, (total < BROKEN_MAX) ? total : BROKEN_MAX);
		for (int p = 0; p < total; p++) begin
			if ($urandom_range(0, 19) == 0) send_drain();
			send_pixel();
		end
		if (!broken) begin
			while (drain_would_release()) send_drain();
			send_drain();
		end
	endtask

	stim_row_t dir_tab [DIR_N] = '{
		'{ROW_CFG, REG_FRAME_WIDTH,  13'd0,    24'h0,      1'b0, '0},
		'{ROW_CFG, REG_FRAME_HEIGHT, 13'd0,    24'h0,      1'b0, '0},
		'{ROW_PIX, '0,               '0,       24'hffffff, 1'b0, '0},
		'{ROW_DRN, '0,               '0,       24'h0,      1'b1, {24'hffffff, 1'b1}},
		'{ROW_DRN, '0,               '0,       24'h0,      1'b0, '0},
		'{ROW_PIX, '0,               '0,       24'h000000, 1'b0, '0},
		'{ROW_DRN, '0,               '0,       24'hffffff, 1'b1, {24'h000000, 1'b1}},
		'{ROW_PIX, '0,               '0,       24'h010203, 1'b0, '0},
		'{ROW_DRN, '0,               '0,       24'h0,      1'b1, {24'h010203, 1'b1}},
		'{ROW_CFG, REG_SPARE_2,      13'h1fff, 24'h0,      1'b0, '0},
		'{ROW_CFG, REG_SPARE_3,      13'd0,    24'h0,      1'b0, '0},
		'{ROW_CFG, REG_FRAME_WIDTH,  13'd3,    24'h0,      1'b0, '0},
		'{ROW_CFG, REG_FRAME_HEIGHT, 13'd2,    24'h0,      1'b0, '0},
		'{ROW_PIX, '0,               '0,       24'h102030, 1'b0, '0},
		'{ROW_PIX, '0,               '0,       24'hff0080, 1'b0, '0},
		'{ROW_DRN, '0,               '0,       24'h0,      1'b0, '0},
		'{ROW_PIX, '0,               '0,       24'h00ff7f, 1'b0, '0},
		'{ROW_PIX, '0,               '0,       24'h01fe02, 1'b0, '0},
		'{ROW_PIX, '0,               '0,       24'h808080, 1'b0, '0},
		'{ROW_PIX, '0,               '0,       24'hffff00, 1'b0, '0},
		'{ROW_DRN, '0,               '0,       24'h0,      1'b0, '0},
		'{ROW_DRN, '0,               '0,       24'h0,      1'b0, '0},
		'{ROW_DRN, '0,               '0,       24'h0,      1'b0, '0},
		'{ROW_DRN, '0,               '0,       24'h0,      1'b0, '0}
	};

	// Output stalls: mostly short, a few long, none while quiet.
	int stall_left = 0;
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			pix_out_if.ready <= 1'b0;
		end else begin
			pix_out_if.ready <= 1'b1;
			if ($urandom_range(0, 99) < 20) stall_left <= gap_len();
		end
	end

	always @(posedge clk) begin
		bbl_out_t want;
		if (arst_n && pix_out_if.valid && pix_out_if.ready) begin
			if (blurred_q.size() == 0) begin
				$display("%0t: unexpected result %p", $time, pix_out_if.data);
				mismatch_count++;
			end else begin
				want = blurred_q.pop_front();
				if (pix_out_if.data.red_out !== want.red_out) begin
					$display("%0t: red expected %0d got %0d", $time,
						want.red_out, pix_out_if.data.red_out);
					mismatch_count++;
				end
				if (pix_out_if.data.green_out !== want.green_out) begin
					$display("%0t: green expected %0d got %0d", $time,
						want.green_out, pix_out_if.data.green_out);
					mismatch_count++;
				end
				if (pix_out_if.data.blue_out !== want.blue_out) begin
					$display("%0t: blue expected %0d got %0d", $time,
						want.blue_out, pix_out_if.data.blue_out);
					mismatch_count++;
				end
				if (pix_out_if.data.frame_end !== want.frame_end) begin
					$display("%0t: frame_end expected %0b got %0b", $time,
						want.frame_end, pix_out_if.data.frame_end);
					mismatch_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((pix_in_if.valid && pix_in_if.ready) || (pix_out_if.valid && pix_out_if.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		bbl_in_t d;
		pix_in_if.valid = 1'b0;
		pix_in_if.data  = '0;
		blur_reset();
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;

		quiet = 1'b1;
		foreach (dir_tab[i]) begin
			if (dir_tab[i].kind == ROW_CFG) begin
				write_reg(dir_tab[i].idx, dir_tab[i].val);
			end else begin
				d.cmd = (dir_tab[i].kind == ROW_DRN) ? 1'(CMD_DRAIN) : 1'(CMD_PIXEL);
				{d.red_in, d.green_in, d.blue_in} = dir_tab[i].rgb;
				send(d, dir_tab[i].typed, dir_tab[i].want);
			end
		end
		quiet = 1'b0;

		// Widest frame, width above range saturating; a single row, cut short.
		write_reg(REG_FRAME_WIDTH, 13'd2047);
		write_reg(REG_FRAME_HEIGHT, 13'd1);
		run_frames(1, 1'b1);
		// Tallest frame, height above range saturating; cut short.
		write_reg(REG_FRAME_WIDTH, 13'd1);
		write_reg(REG_FRAME_HEIGHT, 13'h1fff);
		run_frames(1, 1'b1);

		for (int ph = 0; ph < 12; ph++) begin
			quiet = ($urandom_range(0, 4) == 0);
			write_reg(REG_FRAME_WIDTH, CFG_DATA_W'($urandom_range(1, 9)));
			write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'($urandom_range(1, 6)));
			run_frames($urandom_range(1, 3), $urandom_range(0, 4) == 0);
		end

		@(negedge clk);
		pix_in_if.valid <= 1'b0;
		while (blurred_q.size() != 0) @(posedge clk);
		repeat (IDLE_WAIT) @(posedge clk);
		if (mismatch_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule
